[rtl/rvalu_pkg.sv]
package rvalu_pkg;

	typedef enum logic [4:0] {
		OP_ADD    = 5'd0,
		OP_SUB    = 5'd1,
		OP_SLT    = 5'd2,
		OP_SLTU   = 5'd3,
		OP_AND    = 5'd4,
		OP_OR     = 5'd5,
		OP_XOR    = 5'd6,
		OP_SLL    = 5'd7,
		OP_SRL    = 5'd8,
		OP_SRA    = 5'd9,
		OP_MUL    = 5'd10,
		OP_MULH   = 5'd11,
		OP_MULHSU = 5'd12,
		OP_MULHU  = 5'd13,
		OP_DIV    = 5'd14,
		OP_DIVU   = 5'd15,
		OP_REM    = 5'd16,
		OP_REMU   = 5'd17
	} op_t;

	localparam logic [31:0] UNDEF_PATTERN = 32'hcafebabe;
	localparam int unsigned XLEN = 32;

	typedef struct packed {
		logic [4:0]  op;
		logic [31:0] res;
		logic [31:0] rem;
		logic [31:0] dq;
		logic [31:0] dvs;
		logic        qneg;
		logic        rneg;
		logic        dz;
	} div_pipe_t;

endpackage

[rtl/rvalu_div_stage.sv]
module rvalu_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                vld_in,
	input  rvalu_pkg::div_pipe_t pipe_in,
	output logic                vld_out,
	output rvalu_pkg::div_pipe_t pipe_out
);
	import rvalu_pkg::*;

	logic [32:0] rem_sh;
	logic [32:0] diff;
	div_pipe_t   nxt;

	always_comb begin
		rem_sh = {pipe_in.rem, pipe_in.dq[XLEN-1]};
		diff   = rem_sh - {1'b0, pipe_in.dvs};
		nxt    = pipe_in;
		if (!diff[32]) begin
			nxt.rem = diff[31:0];
			nxt.dq  = {pipe_in.dq[30:0], 1'b1};
		end else begin
			nxt.rem = rem_sh[31:0];
			nxt.dq  = {pipe_in.dq[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (adv) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_out <= nxt;
		end
	end

endmodule

[rtl/rv32im_integer_alu.sv]
// RV32IM integer ALU, fully pipelined.
// Request channel: req_valid with action, operand_a, operand_b; the block
// raises req_stall to hold the item. An item is taken at a clock edge with
// req_valid high and req_stall low.
// Response channel: rsp_valid with alu_result; the receiver raises rsp_stall
// to hold it. One result leaves for each item taken, in order.
// Path: the accepting edge loads the input stage, then come an
// operand/multiply stage, a multiply fix-up stage, one restoring step per
// stage over 32 stages, and the output register that drives rsp_valid.
// Every operation takes the same path, so order is kept.
// Throughput: one item per cycle while the receiver does not stall.
// Stall: the whole pipeline holds while a result waits under rsp_stall;
// req_stall is then high. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once; no item is in flight after.
// Division or remainder by zero gives 0; the 32x32 multiply is one stage.
module rv32im_integer_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [4:0]  action,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic signed [31:0] alu_result
);
	import rvalu_pkg::*;

	localparam int unsigned NSTEP = XLEN;

	logic adv;
	assign adv       = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	logic        v_s1;
	logic [4:0]  op_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= action;
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	logic [4:0]  shamt;
	logic [31:0] simple;
	logic [31:0] mag_a;
	logic [31:0] mag_b;
	logic        sgn_op;

	always_comb begin
		shamt  = b_s1[4:0];
		sgn_op = (op_s1 == OP_DIV) || (op_s1 == OP_REM);
		mag_a  = (sgn_op && a_s1[31]) ? (32'd0 - a_s1) : a_s1;
		mag_b  = (sgn_op && b_s1[31]) ? (32'd0 - b_s1) : b_s1;
		case (op_s1) inside
			OP_ADD:  simple = a_s1 + b_s1;
			OP_SUB:  simple = a_s1 - b_s1;
			OP_SLT:  simple = {31'd0, $signed(a_s1) < $signed(b_s1)};
			OP_SLTU: simple = {31'd0, a_s1 < b_s1};
			OP_AND:  simple = a_s1 & b_s1;
			OP_OR:   simple = a_s1 | b_s1;
			OP_XOR:  simple = a_s1 ^ b_s1;
			OP_SLL:  simple = a_s1 << shamt;
			OP_SRL:  simple = a_s1 >> shamt;
			OP_SRA:  simple = 32'($signed(a_s1) >>> shamt);
			OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
			OP_DIV, OP_DIVU, OP_REM, OP_REMU: simple = '0;
			default: simple = UNDEF_PATTERN;
		endcase
	end

	logic        v_s2;
	logic [4:0]  op_s2;
	logic [31:0] a_s2;
	logic [31:0] b_s2;
	logic [63:0] prod_s2;
	logic [31:0] simple_s2;
	logic [31:0] mag_a_s2;
	logic [31:0] mag_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			a_s2      <= a_s1;
			b_s2      <= b_s1;
			prod_s2   <= {32'd0, a_s1} * {32'd0, b_s1};
			simple_s2 <= simple;
			mag_a_s2  <= mag_a;
			mag_b_s2  <= mag_b;
		end
	end

	logic [31:0] fix_a;
	logic [31:0] fix_b;
	div_pipe_t   head;

	always_comb begin
		fix_a = a_s2[31] ? b_s2 : 32'd0;
		fix_b = b_s2[31] ? a_s2 : 32'd0;
		head      = '0;
		head.op   = op_s2;
		head.rem  = '0;
		head.dq   = mag_a_s2;
		head.dvs  = mag_b_s2;
		head.qneg = a_s2[31] ^ b_s2[31];
		head.rneg = a_s2[31];
		head.dz   = (b_s2 == 32'd0);
		case (op_s2)
			OP_MUL:    head.res = prod_s2[31:0];
			OP_MULH:   head.res = prod_s2[63:32] - fix_a - fix_b;
			OP_MULHSU: head.res = prod_s2[63:32] - fix_a;
			OP_MULHU:  head.res = prod_s2[63:32];
			default:   head.res = simple_s2;
		endcase
	end

	logic      v_s3;
	div_pipe_t pipe_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s3 <= head;
		end
	end

	logic      stg_vld [NSTEP+1];
	div_pipe_t stg     [NSTEP+1];

	assign stg_vld[0] = v_s3;
	assign stg[0]     = pipe_s3;

	for (genvar k = 0; k < NSTEP; k++) begin : g_div
		rvalu_div_stage u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.vld_in   (stg_vld[k]),
			.pipe_in  (stg[k]),
			.vld_out  (stg_vld[k+1]),
			.pipe_out (stg[k+1])
		);
	end

	div_pipe_t   tail;
	logic [31:0] fin;

	always_comb begin
		tail = stg[NSTEP];
		case (tail.op)
			OP_DIV:  fin = tail.dz ? 32'd0 : (tail.qneg ? 32'd0 - tail.dq : tail.dq);
			OP_DIVU: fin = tail.dz ? 32'd0 : tail.dq;
			OP_REM:  fin = tail.dz ? 32'd0 : (tail.rneg ? 32'd0 - tail.rem : tail.rem);
			OP_REMU: fin = tail.dz ? 32'd0 : tail.rem;
			default: fin = tail.res;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= stg_vld[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alu_result <= fin;
		end
	end

endmodule

[rtl/rvalu_checker.sv]
module rvalu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] alu_result
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(alu_result))
		else $error("result changed under stall");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held result");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

endmodule

bind rv32im_integer_alu rvalu_checker u_rvalu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.alu_result (alu_result)
);

[tb/rv32im_integer_alu_tb.sv]
`timescale 1ns / 1ps

module rv32im_integer_alu_tb;
	import rvalu_pkg::*;

	class alu_scoreboard;
		logic [31:0] pending[$];
		int errors;

		function logic [31:0] compute(logic [4:0] op, logic [31:0] a, logic [31:0] b);
			logic [63:0] p;
			logic [31:0] ma, mb, q, r;
			logic [4:0] s;
			s = b[4:0];
			ma = a[31] ? -a : a;
			mb = b[31] ? -b : b;
			case (op)
				OP_ADD: return a + b;
				OP_SUB: return a - b;
				OP_SLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
				OP_SLTU: return (a < b) ? 32'd1 : 32'd0;
				OP_AND: return a & b;
				OP_OR: return a | b;
				OP_XOR: return a ^ b;
				OP_SLL: return a << s;
				OP_SRL: return a >> s;
				OP_SRA: return $signed(a) >>> s;
				OP_MUL: return a * b;
				OP_MULH: begin
					p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
					return p[63:32];
				end
				OP_MULHSU: begin
					p = {{32{a[31]}}, a} * {32'd0, b};
					return p[63:32];
				end
				OP_MULHU: begin
					p = {32'd0, a} * {32'd0, b};
					return p[63:32];
				end
				OP_DIV: begin
					if (b == 0) return 32'd0;
					q = ma / mb;
					return (a[31] ^ b[31]) ? -q : q;
				end
				OP_DIVU: return (b == 0) ? 32'd0 : a / b;
				OP_REM: begin
					if (b == 0) return 32'd0;
					r = ma % mb;
					return a[31] ? -r : r;
				end
				OP_REMU: return (b == 0) ? 32'd0 : a % b;
				default: return UNDEF_PATTERN;
			endcase
		endfunction

		function void note_request(logic [4:0] op, logic [31:0] a, logic [31:0] b);
			pending.push_back(compute(op, a, b));
		endfunction

		function void check_result(logic [31:0] got);
			logic [31:0] want;
			if (pending.size() == 0) begin
				report_mismatch("result with no item pending", got, 32'bx);
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report_mismatch("alu_result", got, want);
		endfunction

		function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
			errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	logic [4:0] action = 0;
	logic signed [31:0] operand_a = 0;
	logic signed [31:0] operand_b = 0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic signed [31:0] alu_result;

	alu_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	rv32im_integer_alu DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(alu_result);
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		action <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(op, a, b);
	endtask

	task automatic go_quiet();
		req_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'hffff_ffff;
			2: return 32'd0;
			3: return $urandom_range(31);
			4: return -$urandom_range(16);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int n);
		logic [4:0] op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(OP_REMU));
			send_item(op, pick_operand(), pick_operand());
		end
	endtask

	initial begin
		logic [31:0] edges[4];
		edges = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int op = 0; op <= OP_REMU; op++)
			send_item(5'(op), edges[op % 4], edges[(op + 1) % 4]);
		send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_item(OP_REM, 32'h8000_0000, 32'hffff_ffff);
		send_item(OP_DIVU, 32'd7, 32'd0);
		send_item(OP_REM, 32'hffff_fff9, 32'd2);
		send_item(OP_SRA, 32'h8000_0000, 32'hffff_ffe4);
		send_item(5'd31, 32'd1, 32'd2);
		go_quiet();
		while (sb.pending.size() != 0) @(posedge clk);
		@(posedge clk);

		random_items(500);
		send_idle_pct = 58;
		random_items(450);
		send_idle_pct = 0;
		recv_stall_pct = 58;
		random_items(450);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		random_items(250);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_items(250);
		go_quiet();

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
